### rtl/core/mtbr_pkg.sv
// Package for the bounded MT19937 random unit: word and index types, generator constants,
// and the tempering, twist and mask-smearing functions. It depends on nothing else.
package mtbr_pkg;

	localparam int WORD_W       = 32;
	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = $clog2(STATE_WORDS);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam word_t INIT_MULT  = 32'd1812433253;
	localparam word_t MATRIX_A   = 32'h9908_b0df;
	localparam word_t TEMPER_B   = 32'h9d2c_5680;
	localparam word_t TEMPER_C   = 32'hefc6_0000;
	localparam word_t UPPER_MASK = 32'h8000_0000;
	localparam word_t LOWER_MASK = 32'h7fff_ffff;
	localparam word_t SEED_RESET = 32'hfedc_ba09;

	localparam idx_t LAST_IDX   = idx_t'(STATE_WORDS - 1);
	localparam idx_t OFFSET_IDX = idx_t'(TWIST_OFFSET);
	localparam idx_t DEPTH_IDX  = idx_t'(STATE_WORDS);

	// Output tempering of one state word.
	function automatic word_t temper(input word_t y);
		word_t t1;
		word_t t2;
		word_t t3;
		t1 = y ^ (y >> 11);
		t2 = t1 ^ ((t1 << 7) & TEMPER_B);
		t3 = t2 ^ ((t2 << 15) & TEMPER_C);
		return t3 ^ (t3 >> 18);
	endfunction

	// New value of one state word from itself, its successor and the word one offset ahead.
	function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
		word_t y;
		y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		return far ^ (y >> 1) ^ (nxt[0] ? MATRIX_A : '0);
	endfunction

	// All-ones mask covering the highest set bit of the limit.
	function automatic word_t smear(input word_t v);
		word_t m;
		m = v;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		return m;
	endfunction

endpackage

### rtl/core/mtbr_if.sv
// Valid/ready stream interfaces for the request limit and the returned value.
// Depends on mtbr_pkg for the word width.
interface mtbr_limit_if;
	logic                        valid;
	logic                        ready;
	logic [mtbr_pkg::WORD_W-1:0] limit;

	modport source(output valid, output limit, input ready);
	modport sink(input valid, input limit, output ready);
endinterface

interface mtbr_value_if;
	logic                        valid;
	logic                        ready;
	logic [mtbr_pkg::WORD_W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

### rtl/core/mt19937_bounded_random_unit.sv
// Top level of the bounded MT19937 random unit: state memory, seeding, twisting and draws.
// Depends on mtbr_pkg and on the stream interfaces in mtbr_if.sv.
//
//   Channel     Direction  Payload            Handshake
//   req         in         limit  (32 bit)    valid / ready
//   rsp         out        value  (32 bit)    valid / ready
//   seed        in         seed_wdata (32)    seed_we, no wait, no read-back
//
// A request reads the state word, then tempers, masks and compares it; every rejected
// draw repeats the read and the compare.
// Each twist of the state reads and writes back one word at a time and occurs after
// every 624 words consumed; a request that is still drawing then waits for the twist.
// After reset and after each seed write, the state is seeded and then twisted before
// the first request is taken.
// A request is taken while an earlier result still waits on rsp; a new result that finds
// the output register full holds in the compare stage until rsp is taken.
module mt19937_bounded_random_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	mtbr_limit_if.sink                  req,
	mtbr_value_if.source                rsp,
	input  logic                        seed_we,
	input  logic [mtbr_pkg::WORD_W-1:0] seed_wdata
);
	import mtbr_pkg::*;

	typedef enum logic [3:0] {
		ST_SEED_INIT,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_TW_PRE,
		ST_TW_RD,
		ST_TW_WR,
		ST_IDLE,
		ST_DRAW_RD,
		ST_DRAW
	} state_t;

	state_t state_q;

	// The generator state lives in one synchronous memory with a write port and two
	// registered read ports. Port b is only used for the word one offset ahead in a twist.
	word_t mem [STATE_WORDS];
	word_t rd_a_q;
	word_t rd_b_q;

	logic  mem_we;
	idx_t  wr_addr;
	word_t wr_data;
	logic  rd_en_a;
	logic  rd_en_b;
	idx_t  rd_addr_a;
	idx_t  rd_addr_b;

	word_t seed_q;
	word_t prev_q;      // last word written while seeding
	word_t prod_q;      // registered product of the initializer
	word_t cur_q;       // untwisted value of the word being twisted
	idx_t  k_q;         // word index during seeding and twisting
	idx_t  idx_q;       // next unused word for draws
	logic  draw_pend_q; // a rejected draw waits for the twist to finish
	word_t limit_q;
	word_t mask_q;
	logic  rsp_valid_q;
	word_t rsp_value_q;

	idx_t  nxt_addr;
	idx_t  far_sum;
	idx_t  far_addr;
	word_t seed_word;
	word_t draw_val;
	logic  draw_ok;
	logic  out_free;
	logic  out_load;

	// Neighbour addresses for the twist, wrapped round the end of the state.
	assign nxt_addr  = (k_q == LAST_IDX) ? '0 : k_q + idx_t'(1);
	assign far_sum   = k_q + OFFSET_IDX;
	assign far_addr  = (far_sum >= DEPTH_IDX) ? far_sum - DEPTH_IDX : far_sum;

	assign seed_word = prod_q + word_t'(k_q);

	// A draw masks the tempered word and is accepted when it does not exceed the limit.
	assign draw_val  = temper(rd_a_q) & mask_q;
	assign draw_ok   = (draw_val <= limit_q);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign out_load  = (state_q == ST_DRAW) && draw_ok && out_free && !seed_we;

	// A request is never taken in the cycle of a seed write, which restarts the unit.
	assign req.ready = (state_q == ST_IDLE) && !seed_we;
	assign rsp.valid = rsp_valid_q;
	assign rsp.value = rsp_value_q;

	// Memory port control. Reads and writes never fall in the same cycle: a twist step
	// reads in one cycle and writes back in the next, so no forwarding is needed.
	always_comb begin
		mem_we    = 1'b0;
		wr_addr   = k_q;
		wr_data   = seed_word;
		rd_en_a   = 1'b0;
		rd_en_b   = 1'b0;
		rd_addr_a = idx_q;
		rd_addr_b = far_addr;
		unique case (state_q)
			ST_SEED_INIT: begin
				mem_we  = 1'b1;
				wr_addr = '0;
				wr_data = seed_q;
			end
			ST_SEED_ADD: begin
				mem_we = 1'b1;
			end
			ST_TW_PRE: begin
				rd_en_a   = 1'b1;
				rd_addr_a = '0;
			end
			ST_TW_RD: begin
				rd_en_a   = 1'b1;
				rd_en_b   = 1'b1;
				rd_addr_a = nxt_addr;
			end
			ST_TW_WR: begin
				mem_we  = 1'b1;
				wr_data = twist_word(cur_q, rd_a_q, rd_b_q);
			end
			ST_IDLE: begin
				rd_en_a = req.valid;
			end
			ST_DRAW_RD: begin
				rd_en_a = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED_INIT;
			seed_q      <= SEED_RESET;
			prev_q      <= '0;
			prod_q      <= '0;
			cur_q       <= '0;
			k_q         <= '0;
			idx_q       <= '0;
			draw_pend_q <= 1'b0;
			limit_q     <= '0;
			mask_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_value_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && !out_load) begin
				rsp_valid_q <= 1'b0;
			end
			if (seed_we) begin
				// A seed write restarts the state from scratch.
				seed_q      <= seed_wdata;
				draw_pend_q <= 1'b0;
				state_q     <= ST_SEED_INIT;
			end else begin
				unique case (state_q)
					ST_SEED_INIT: begin
						prev_q  <= seed_q;
						k_q     <= idx_t'(1);
						state_q <= ST_SEED_MUL;
					end
					ST_SEED_MUL: begin
						prod_q  <= INIT_MULT * (prev_q ^ (prev_q >> 30));
						state_q <= ST_SEED_ADD;
					end
					ST_SEED_ADD: begin
						prev_q <= seed_word;
						if (k_q == LAST_IDX) begin
							k_q     <= '0;
							state_q <= ST_TW_PRE;
						end else begin
							k_q     <= k_q + idx_t'(1);
							state_q <= ST_SEED_MUL;
						end
					end
					ST_TW_PRE: begin
						state_q <= ST_TW_RD;
					end
					ST_TW_RD: begin
						// The first word of a twist comes from the read issued before it.
						if (k_q == '0) begin
							cur_q <= rd_a_q;
						end
						state_q <= ST_TW_WR;
					end
					ST_TW_WR: begin
						// The successor just read is still untwisted: it is the next step's word.
						cur_q <= rd_a_q;
						if (k_q == LAST_IDX) begin
							k_q         <= '0;
							idx_q       <= '0;
							draw_pend_q <= 1'b0;
							state_q     <= draw_pend_q ? ST_DRAW_RD : ST_IDLE;
						end else begin
							k_q     <= k_q + idx_t'(1);
							state_q <= ST_TW_RD;
						end
					end
					ST_IDLE: begin
						if (req.valid) begin
							limit_q <= req.limit;
							mask_q  <= smear(req.limit);
							state_q <= ST_DRAW;
						end
					end
					ST_DRAW_RD: begin
						state_q <= ST_DRAW;
					end
					ST_DRAW: begin
						if (!draw_ok || out_free) begin
							if (draw_ok) begin
								rsp_value_q <= draw_val;
								rsp_valid_q <= 1'b1;
							end
							// The word is consumed whether accepted or rejected.
							if (idx_q == LAST_IDX) begin
								k_q         <= '0;
								draw_pend_q <= !draw_ok;
								state_q     <= ST_TW_PRE;
							end else begin
								idx_q   <= idx_q + idx_t'(1);
								state_q <= draw_ok ? ST_IDLE : ST_DRAW_RD;
							end
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// The draw index always points inside the state.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("draw index beyond the state");

	// A result loaded into the output register never exceeds the request's limit.
	a_value_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (rsp_value_q <= limit_q))
		else $error("result above limit");

	// Writes never meet a read of the same entry, so no forwarding path is required.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !(rd_en_a || rd_en_b))
		else $error("memory read and write in the same cycle");

	// The compare stage holds its read data: nothing is read or written while it waits.
	a_draw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) && draw_ok && !out_free && !seed_we
		|=> (state_q == ST_DRAW) && $stable(rd_a_q))
		else $error("stalled draw lost its word");

endmodule
